[design/wbit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbit_pkg: shared definitions for the work/break interval timer
// Field widths, reset values, display constants, codes and the microcode
// table that sequences one pass of the timer.
// ----------------------------------------------------------------------------
package wbit_pkg;

   // default strip length
   localparam int PIXEL_COUNT_DEF = 25;

   // field widths
   localparam int TIME_W  = 32;
   localparam int LEN_W   = 24;
   localparam int CYCLE_W = LEN_W + 1;
   localparam int PRESS_W = 16;
   localparam int CNT_W   = 5;
   localparam int UPC_W   = 4;

   localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

   // register reset values
   localparam logic [23:0] WORK_MS_RST    = 24'd2820000;
   localparam logic [23:0] BREAK_MS_RST   = 24'd780000;
   localparam logic [7:0]  PRESS_THR_RST  = 8'd10;
   localparam logic [3:0]  FLASHES_RST    = 4'd4;
   localparam logic [7:0]  ALERT_GRP_RST  = 8'd10;

   // display constants
   localparam logic [5:0] ALERT_RED    = 6'd60;
   localparam logic [4:0] ALERT_GREEN  = 5'd20;
   localparam logic [5:0] ALERT_BLUE   = 6'd60;
   localparam logic [5:0] BAR_RED      = 6'd20;
   localparam logic [4:0] BAR_GREEN    = 5'd6;
   localparam logic [5:0] BAR_BLUE     = 6'd20;
   localparam logic [4:0] FLASH_ON_MS  = 5'd20;
   localparam logic [4:0] BAR_MS       = 5'd10;
   localparam logic [8:0] FLASH_OFF_MS = 9'd80;
   localparam logic [8:0] GROUP_GAP_MS = 9'd400;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_WORK_MS      = 3'd0,
      CSR_BREAK_MS     = 3'd1,
      CSR_PRESS_THR    = 3'd2,
      CSR_FLASHES      = 3'd3,
      CSR_ALERT_GROUPS = 3'd4
   } csr_index_type;

   // display command codes
   typedef enum logic [1:0] {
      ACT_FLASH = 2'd0,
      ACT_NONE  = 2'd1,
      ACT_BAR   = 2'd2
   } action_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_WAIT,
      OP_PRESS,
      OP_NOP,
      OP_TOGGLE,
      OP_MOD_LOAD,
      OP_DIV_STEP,
      OP_POS,
      OP_CHECK,
      OP_SCALE,
      OP_BAR,
      OP_FLASH,
      OP_GROUP,
      OP_EMIT
   } op_type;

   // sequencer branch conditions
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_JUMP,
      BR_FLASH,
      BR_GROUP,
      BR_BUSY,
      BR_CHANGE,
      BR_WAIT_IN,
      BR_WAIT_OUT
   } br_type;

   typedef struct packed {
      op_type            op;
      br_type            br;
      logic [UPC_W-1:0]  target;
   } uword_type;

   // program addresses
   localparam logic [UPC_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [UPC_W-1:0] ST_PRESS    = 4'd1;
   localparam logic [UPC_W-1:0] ST_GRPCHK   = 4'd2;
   localparam logic [UPC_W-1:0] ST_TOGGLE   = 4'd3;
   localparam logic [UPC_W-1:0] ST_MOD_LOAD = 4'd4;
   localparam logic [UPC_W-1:0] ST_MOD_LOOP = 4'd5;
   localparam logic [UPC_W-1:0] ST_POS      = 4'd6;
   localparam logic [UPC_W-1:0] ST_CHECK    = 4'd7;
   localparam logic [UPC_W-1:0] ST_SCALE    = 4'd8;
   localparam logic [UPC_W-1:0] ST_DIV_LOOP = 4'd9;
   localparam logic [UPC_W-1:0] ST_BAR      = 4'd10;
   localparam logic [UPC_W-1:0] ST_FLASH    = 4'd11;
   localparam logic [UPC_W-1:0] ST_GROUP    = 4'd12;
   localparam logic [UPC_W-1:0] ST_EMIT     = 4'd13;

   // microcode table: one control word per program step
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] addr);
      uword_type w;
      case (addr)
         ST_IDLE:     w = '{OP_WAIT,     BR_WAIT_IN,  ST_PRESS};
         ST_PRESS:    w = '{OP_PRESS,    BR_FLASH,    ST_FLASH};
         ST_GRPCHK:   w = '{OP_NOP,      BR_GROUP,    ST_GROUP};
         ST_TOGGLE:   w = '{OP_TOGGLE,   BR_NEXT,     ST_IDLE};
         ST_MOD_LOAD: w = '{OP_MOD_LOAD, BR_NEXT,     ST_IDLE};
         ST_MOD_LOOP: w = '{OP_DIV_STEP, BR_BUSY,     ST_MOD_LOOP};
         ST_POS:      w = '{OP_POS,      BR_NEXT,     ST_IDLE};
         ST_CHECK:    w = '{OP_CHECK,    BR_CHANGE,   ST_EMIT};
         ST_SCALE:    w = '{OP_SCALE,    BR_NEXT,     ST_IDLE};
         ST_DIV_LOOP: w = '{OP_DIV_STEP, BR_BUSY,     ST_DIV_LOOP};
         ST_BAR:      w = '{OP_BAR,      BR_JUMP,     ST_EMIT};
         ST_FLASH:    w = '{OP_FLASH,    BR_JUMP,     ST_EMIT};
         ST_GROUP:    w = '{OP_GROUP,    BR_JUMP,     ST_EMIT};
         ST_EMIT:     w = '{OP_EMIT,     BR_WAIT_OUT, ST_IDLE};
         default:     w = '{OP_NOP,      BR_JUMP,     ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

[design/work_break_interval_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_break_interval_timer: work/break timer with progress bar and alerts
// Microcoded sequencer: a step counter walks a control table that drives a
// press integrator, phase state and a shared shift-subtract divider.
// ----------------------------------------------------------------------------
// Passes: a flash pulse runs press, flash and emit; a group start runs press,
//   group check, group and emit; a phase change runs press through check and
//   emit; the bar adds scale, division loop and bar. Throughput: one beat per
//   pass, emit holding while a result stalls; the divider's 32-step modulo loop
//   dominates. A new beat is taken while the last result still waits.
// Reset: synchronous, active high; registers return to their defaults,
//   phase is work, origin 0, no alert pending, press count 0.
module work_break_interval_timer
   import wbit_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_button_down,
   input  logic [31:0] req_now_ms,
   // result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [5:0]  rsp_red,
   output logic [4:0]  rsp_green,
   output logic [5:0]  rsp_blue,
   output logic [4:0]  rsp_lit_count,
   output logic [4:0]  rsp_lit_ms,
   output logic [8:0]  rsp_dark_ms,
   output logic        rsp_in_work,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // quotient of the bar division stays below PIXEL_COUNT
   localparam int QBITS = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [6:0] PIX7 = 7'(PIXEL_COUNT);

   // sequencer
   logic [UPC_W-1:0]   pc_ff, pc_in;
   uword_type          cw;

   // configuration
   logic [LEN_W-1:0]   work_ms_ff, work_ms_in;
   logic [LEN_W-1:0]   break_ms_ff, break_ms_in;
   logic [7:0]         press_thr_ff, press_thr_in;
   logic [3:0]         flashes_ff, flashes_in;
   logic [7:0]         alert_grp_ff, alert_grp_in;

   // timer state
   logic               phase_is_work_ff, phase_is_work_in;
   logic [TIME_W-1:0]  phase_origin_ff, phase_origin_in;
   logic               alert_is_work_ff, alert_is_work_in;
   logic [4:0]         flash_left_ff, flash_left_in;
   logic [7:0]         groups_left_ff, groups_left_in;
   logic [PRESS_W-1:0] press_count_ff, press_count_in;

   // latched input beat
   logic               button_ff, button_in;
   logic [TIME_W-1:0]  now_ff, now_in;

   // divider and bar working registers
   logic [CYCLE_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0]  quo_ff, quo_in;
   logic [CYCLE_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic               div_zero_ff, div_zero_in;
   logic [CYCLE_W-1:0] pos_ff, pos_in;
   logic               working_ff, working_in;
   action_type         kind_ff, kind_in;
   logic [4:0]         bar_lit_ff, bar_lit_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_action_ff, rsp_action_in;
   logic [5:0]         rsp_red_ff, rsp_red_in;
   logic [4:0]         rsp_green_ff, rsp_green_in;
   logic [5:0]         rsp_blue_ff, rsp_blue_in;
   logic [4:0]         rsp_lit_ff, rsp_lit_in;
   logic [4:0]         rsp_lit_ms_ff, rsp_lit_ms_in;
   logic [8:0]         rsp_dark_ff, rsp_dark_in;
   logic               rsp_in_work_ff, rsp_in_work_in;

   // helpers
   logic               in_accept;
   logic               out_free;
   logic               change;
   logic [CYCLE_W-1:0] work_ext;
   logic [CYCLE_W-1:0] cycle_len;
   logic [CYCLE_W:0]   trial;
   logic [CYCLE_W:0]   trial_diff;
   logic               fits;
   logic [CYCLE_W-1:0] scale_x;
   logic [TIME_W-1:0]  scale_prod;
   logic [CYCLE_W-1:0] scale_div;
   logic [6:0]         bar_q;
   logic [6:0]         bar_comp;

   // fetch the control word of the current step
   always_comb begin
      cw = ucode_rom(pc_ff);
   end

   assign in_accept = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign change    = phase_is_work_ff != working_ff;
   assign req_stall = cw.op != OP_WAIT;
   assign csr_ready = 1'b1;

   // pick the next program step
   always_comb begin
      case (cw.br)
         BR_NEXT:     pc_in = pc_ff + 4'd1;
         BR_JUMP:     pc_in = cw.target;
         BR_FLASH:    pc_in = (flash_left_ff != 5'd0) ? cw.target : pc_ff + 4'd1;
         BR_GROUP:    pc_in = (groups_left_ff != 8'd0) ? cw.target : pc_ff + 4'd1;
         BR_BUSY:     pc_in = (div_cnt_ff != '0) ? cw.target : pc_ff + 4'd1;
         BR_CHANGE:   pc_in = change ? cw.target : pc_ff + 4'd1;
         BR_WAIT_IN:  pc_in = in_accept ? cw.target : pc_ff;
         BR_WAIT_OUT: pc_in = out_free ? cw.target : pc_ff;
         default:     pc_in = ST_IDLE;
      endcase
   end

   // take register writes
   always_comb begin
      work_ms_in   = work_ms_ff;
      break_ms_in  = break_ms_ff;
      press_thr_in = press_thr_ff;
      flashes_in   = flashes_ff;
      alert_grp_in = alert_grp_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORK_MS:      work_ms_in   = csr_wdata;
            CSR_BREAK_MS:     break_ms_in  = csr_wdata;
            CSR_PRESS_THR:    press_thr_in = csr_wdata[7:0];
            CSR_FLASHES:      flashes_in   = csr_wdata[3:0];
            CSR_ALERT_GROUPS: alert_grp_in = csr_wdata[7:0];
            default:          ;
         endcase
      end
   end

   // shared arithmetic of the datapath
   assign work_ext   = {1'b0, work_ms_ff};
   assign cycle_len  = work_ext + {1'b0, break_ms_ff};
   assign trial      = {rem_ff, quo_ff[TIME_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};
   assign scale_x    = working_ff ? pos_ff : pos_ff - work_ext;
   assign scale_prod = {{(TIME_W-CYCLE_W){1'b0}}, scale_x} * 32'(PIXEL_COUNT);
   assign scale_div  = working_ff ? work_ext : {1'b0, break_ms_ff};
   assign bar_q      = div_zero_ff ? 7'd0 : 7'(quo_ff[QBITS-1:0]);
   assign bar_comp   = working_ff ? bar_q :
                       ((bar_q < PIX7) ? PIX7 - 7'd1 - bar_q : 7'd0);

   // datapath: carry out the operation of the current step
   always_comb begin
      phase_is_work_in = phase_is_work_ff;
      phase_origin_in  = phase_origin_ff;
      alert_is_work_in = alert_is_work_ff;
      flash_left_in    = flash_left_ff;
      groups_left_in   = groups_left_ff;
      press_count_in   = press_count_ff;
      button_in        = button_ff;
      now_in           = now_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      divisor_in       = divisor_ff;
      div_cnt_in       = div_cnt_ff;
      div_zero_in      = div_zero_ff;
      pos_in           = pos_ff;
      working_in       = working_ff;
      kind_in          = kind_ff;
      bar_lit_in       = bar_lit_ff;
      rsp_action_in    = rsp_action_ff;
      rsp_red_in       = rsp_red_ff;
      rsp_green_in     = rsp_green_ff;
      rsp_blue_in      = rsp_blue_ff;
      rsp_lit_in       = rsp_lit_ff;
      rsp_lit_ms_in    = rsp_lit_ms_ff;
      rsp_dark_in      = rsp_dark_ff;
      rsp_in_work_in   = rsp_in_work_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      case (cw.op)
         // latch the beat
         OP_WAIT: begin
            if (in_accept) begin
               button_in = req_button_down;
               now_in    = req_now_ms;
            end
         end
         // integrate the button level
         OP_PRESS: begin
            if (button_ff) begin
               if (press_count_ff != PRESS_MAX) begin
                  press_count_in = press_count_ff + 16'd1;
               end
            end else if (press_count_ff != '0) begin
               press_count_in = press_count_ff - 16'd1;
            end
         end
         OP_NOP: begin
         end
         // long press: flip the phase flag and move the origin to the start of the phase it left
         OP_TOGGLE: begin
            if (press_count_ff >= {8'd0, press_thr_ff}) begin
               press_count_in   = '0;
               phase_is_work_in = !phase_is_work_ff;
               phase_origin_in  = now_ff -
                  (phase_is_work_ff ? 32'd0 : {8'd0, work_ms_ff});
            end
         end
         // set up elapsed time modulo cycle length
         OP_MOD_LOAD: begin
            rem_in      = '0;
            quo_in      = now_ff - phase_origin_ff;
            divisor_in  = cycle_len;
            div_zero_in = cycle_len == '0;
            div_cnt_in  = CNT_W'(TIME_W - 1);
         end
         // one restoring division step
         OP_DIV_STEP: begin
            rem_in     = fits ? trial_diff[CYCLE_W-1:0] : trial[CYCLE_W-1:0];
            quo_in     = {quo_ff[TIME_W-2:0], fits};
            div_cnt_in = div_cnt_ff - 5'd1;
         end
         // phase position and its phase
         OP_POS: begin
            pos_in     = div_zero_ff ? '0 : rem_ff;
            working_in = (div_zero_ff ? '0 : rem_ff) < work_ext;
         end
         // phase flag disagrees: follow it and arm an alert
         OP_CHECK: begin
            if (change) begin
               phase_is_work_in = working_ff;
               groups_left_in   = alert_grp_ff;
               alert_is_work_in = working_ff;
               kind_in          = ACT_NONE;
            end
         end
         // scale the offset by the strip length and divide by phase length
         OP_SCALE: begin
            rem_in      = CYCLE_W'(scale_prod >> QBITS);
            quo_in      = scale_prod << (TIME_W - QBITS);
            divisor_in  = scale_div;
            div_zero_in = scale_div == '0;
            div_cnt_in  = CNT_W'(QBITS - 1);
         end
         OP_BAR: begin
            kind_in    = ACT_BAR;
            bar_lit_in = 5'(bar_comp + 7'd1);
         end
         OP_FLASH: begin
            flash_left_in = flash_left_ff - 5'd1;
            kind_in       = ACT_FLASH;
         end
         OP_GROUP: begin
            groups_left_in = groups_left_ff - 8'd1;
            flash_left_in  = 5'({1'b0, flashes_ff} + 5'd1);
            kind_in        = ACT_NONE;
         end
         // build the display command once the result slot is free
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = kind_ff;
               rsp_in_work_in = phase_is_work_ff;
               case (kind_ff)
                  ACT_FLASH: begin
                     rsp_red_in    = alert_is_work_ff ? ALERT_RED : 6'd0;
                     rsp_green_in  = ALERT_GREEN;
                     rsp_blue_in   = alert_is_work_ff ? 6'd0 : ALERT_BLUE;
                     rsp_lit_in    = 5'(PIXEL_COUNT);
                     rsp_lit_ms_in = FLASH_ON_MS;
                     rsp_dark_in   = FLASH_OFF_MS +
                        ((flash_left_ff == 5'd0) ? GROUP_GAP_MS : 9'd0);
                  end
                  ACT_BAR: begin
                     rsp_red_in    = working_ff ? BAR_RED : 6'd0;
                     rsp_green_in  = BAR_GREEN;
                     rsp_blue_in   = working_ff ? 6'd0 : BAR_BLUE;
                     rsp_lit_in    = bar_lit_ff;
                     rsp_lit_ms_in = BAR_MS;
                     rsp_dark_in   = 9'd0;
                  end
                  default: begin
                     rsp_red_in    = 6'd0;
                     rsp_green_in  = 5'd0;
                     rsp_blue_in   = 6'd0;
                     rsp_lit_in    = 5'd0;
                     rsp_lit_ms_in = 5'd0;
                     rsp_dark_in   = 9'd0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff            <= ST_IDLE;
         work_ms_ff       <= WORK_MS_RST;
         break_ms_ff      <= BREAK_MS_RST;
         press_thr_ff     <= PRESS_THR_RST;
         flashes_ff       <= FLASHES_RST;
         alert_grp_ff     <= ALERT_GRP_RST;
         phase_is_work_ff <= 1'b1;
         phase_origin_ff  <= '0;
         alert_is_work_ff <= 1'b0;
         flash_left_ff    <= '0;
         groups_left_ff   <= '0;
         press_count_ff   <= '0;
         div_cnt_ff       <= '0;
         kind_ff          <= ACT_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pc_ff            <= pc_in;
         work_ms_ff       <= work_ms_in;
         break_ms_ff      <= break_ms_in;
         press_thr_ff     <= press_thr_in;
         flashes_ff       <= flashes_in;
         alert_grp_ff     <= alert_grp_in;
         phase_is_work_ff <= phase_is_work_in;
         phase_origin_ff  <= phase_origin_in;
         alert_is_work_ff <= alert_is_work_in;
         flash_left_ff    <= flash_left_in;
         groups_left_ff   <= groups_left_in;
         press_count_ff   <= press_count_in;
         div_cnt_ff       <= div_cnt_in;
         kind_ff          <= kind_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      button_ff      <= button_in;
      now_ff         <= now_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      divisor_ff     <= divisor_in;
      div_zero_ff    <= div_zero_in;
      pos_ff         <= pos_in;
      working_ff     <= working_in;
      bar_lit_ff     <= bar_lit_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_red_ff     <= rsp_red_in;
      rsp_green_ff   <= rsp_green_in;
      rsp_blue_ff    <= rsp_blue_in;
      rsp_lit_ff     <= rsp_lit_in;
      rsp_lit_ms_ff  <= rsp_lit_ms_in;
      rsp_dark_ff    <= rsp_dark_in;
      rsp_in_work_ff <= rsp_in_work_in;
   end

   // drive the result ports
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_lit_count = rsp_lit_ff;
   assign rsp_lit_ms    = rsp_lit_ms_ff;
   assign rsp_dark_ms   = rsp_dark_ff;
   assign rsp_in_work   = rsp_in_work_ff;

   // an accepted beat always starts the pass at the press step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> pc_ff == ST_PRESS)
      else $error("accepted beat did not start a pass");

   // a new result only appears out of the emit step
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == ST_EMIT)
      else $error("result raised outside the emit step");

   // the modulo loop exits to the position step once its count runs out
   a_mod_exit: assert property (@(posedge clock) disable iff (reset)
      pc_ff == ST_MOD_LOOP && div_cnt_ff == '0 |=> pc_ff == ST_POS)
      else $error("modulo loop did not terminate");

   // a flash group never holds more than sixteen pulses
   a_flash_bound: assert property (@(posedge clock) disable iff (reset)
      flash_left_ff <= 5'd16)
      else $error("flash count out of range");

endmodule
